FILE: sv/ftl_pkg.sv
// Package for the flow table lookup: sizes, item types, status and register codes.
`default_nettype none
package ftl_pkg;

  localparam int MAX_FLOWS     = 1024;
  localparam int IDX_W         = $clog2(MAX_FLOWS);
  localparam int CNT_W         = $clog2(MAX_FLOWS + 1);
  localparam int FLOW_INDEX_W  = 10;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;

  localparam logic [31:0] ACTIVE_TIMEOUT_RST   = 32'd60000;
  localparam logic [31:0] INACTIVE_TIMEOUT_RST = 32'd10000;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TIMEOUT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INACTIVE_TIMEOUT = 1'd1;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NEW   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] packet_time;
  } in_item_t;

  typedef struct packed {
    logic [FLOW_INDEX_W-1:0] flow_index;
    logic [1:0]              status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] first_time;
    logic [31:0] last_time;
  } flow_entry_t;

  typedef struct packed {
    logic [31:0] active_timeout;
    logic [31:0] inactive_timeout;
  } timeouts_t;

  function automatic logic [FLOW_INDEX_W-1:0] to_flow_index(input logic [CNT_W-1:0] v);
    return FLOW_INDEX_W'(v);
  endfunction

endpackage
`default_nettype wire

FILE: sv/flow_table_lookup_insert.sv
// Flow table lookup and insert: table memory, scan sequencer and configuration registers.
// An empty table answers in the cycle after start; otherwise the stored flows are
// scanned newest first, one table read and compare per cycle, until a hit or the oldest.
// The single read port serialises the scan; start is only taken while busy is low.
// Reset: flow count cleared and timeouts restored; table contents stay undefined.
// The receiver cannot stall: each result is shown for one cycle on out_valid.
`default_nettype none
module flow_table_lookup_insert
  import ftl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  output out_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic        issue_r, issue_nxt;
  logic        cmp_vld_r, cmp_vld_nxt;
  in_item_t    key_r, key_nxt;
  timeouts_t   tmo_r, tmo_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  flow_entry_t mem [MAX_FLOWS];
  flow_entry_t rd_data_r;
  flow_entry_t wr_data;
  logic        mem_we;
  in_item_t    wr_key;
  logic        hit;

  ftl_match u_match (
    .entry (rd_data_r),
    .key   (key_r),
    .tmo   (tmo_r),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= wr_data;
    end
    rd_data_r <= mem[ptr_r[IDX_W-1:0]];
  end

  assign wr_key = (state_r == S_IDLE) ? in_item : key_r;

  always_comb begin
    wr_data.src_addr   = wr_key.src_addr;
    wr_data.dst_addr   = wr_key.dst_addr;
    wr_data.src_port   = wr_key.src_port;
    wr_data.dst_port   = wr_key.dst_port;
    wr_data.first_time = wr_key.packet_time;
    wr_data.last_time  = wr_key.packet_time;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    cmp_idx_nxt   = ptr_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = (state_r == S_SCAN) && issue_r;
    key_nxt       = key_r;
    tmo_nxt       = tmo_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_TIMEOUT:   tmo_nxt.active_timeout   = cfg_wdata;
        REG_INACTIVE_TIMEOUT: tmo_nxt.inactive_timeout = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt = in_item;
          if (count_r == '0) begin
            mem_we                  = 1'b1;
            count_nxt               = count_r + CNT_W'(1);
            out_valid_nxt           = 1'b1;
            out_item_nxt.flow_index = to_flow_index(count_r);
            out_item_nxt.status     = ST_NEW;
          end else begin
            ptr_nxt   = count_r - CNT_W'(1);
            issue_nxt = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmp_vld_r && hit) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.flow_index = to_flow_index(cmp_idx_r);
          out_item_nxt.status     = ST_FOUND;
          issue_nxt               = 1'b0;
          cmp_vld_nxt             = 1'b0;
          state_nxt               = S_IDLE;
        end else if (cmp_vld_r && (cmp_idx_r == '0)) begin
          out_valid_nxt = 1'b1;
          if (count_r == CNT_W'(MAX_FLOWS)) begin
            out_item_nxt.flow_index = '0;
            out_item_nxt.status     = ST_FULL;
          end else begin
            mem_we                  = 1'b1;
            count_nxt               = count_r + CNT_W'(1);
            out_item_nxt.flow_index = to_flow_index(count_r);
            out_item_nxt.status     = ST_NEW;
          end
          issue_nxt   = 1'b0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end else if (issue_r) begin
          if (ptr_r == '0) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r - CNT_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r                <= S_IDLE;
      count_r                <= '0;
      ptr_r                  <= '0;
      cmp_idx_r              <= '0;
      issue_r                <= 1'b0;
      cmp_vld_r              <= 1'b0;
      tmo_r.active_timeout   <= ACTIVE_TIMEOUT_RST;
      tmo_r.inactive_timeout <= INACTIVE_TIMEOUT_RST;
      out_valid_r            <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      tmo_r       <= tmo_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

FILE: sv/ftl_match.sv
// Compare unit: checks one stored flow entry against the packet key and both timeouts.
`default_nettype none
module ftl_match
  import ftl_pkg::*;
(
  input  wire flow_entry_t entry,
  input  wire in_item_t    key,
  input  wire timeouts_t   tmo,
  output logic             hit
);

  logic [31:0] age;
  logic [31:0] idle;
  logic        key_eq;

  assign age    = key.packet_time - entry.first_time;
  assign idle   = key.packet_time - entry.last_time;
  assign key_eq = (entry.src_addr == key.src_addr) && (entry.dst_addr == key.dst_addr) &&
                  (entry.src_port == key.src_port) && (entry.dst_port == key.dst_port);
  assign hit    = key_eq && (age <= tmo.active_timeout) && (idle <= tmo.inactive_timeout);

endmodule
`default_nettype wire
